FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KPSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpsl assertion failed");

// Next-cycle implication checked outside reset.
`define KPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpsl assertion failed");

`endif

FILE: src/kpsl_pkg.sv
`default_nettype none

package kpsl_pkg;

    localparam logic [7:0] LONG_BASE   = 8'h31;
    localparam logic [7:0] REPEAT_STEP = 8'd4;

    localparam logic       RST_ENABLE  = 1'b1;
    localparam logic       RST_MODE    = 1'b0;
    localparam logic [7:0] RST_SHORT   = 8'd3;
    localparam logic [7:0] RST_LONG    = 8'd100;
    localparam logic [7:0] RST_LOCKOUT = 8'd10;

    typedef enum logic [2:0] {
        CFG_ENABLE  = 3'd0,
        CFG_MODE    = 3'd1,
        CFG_SHORT   = 3'd2,
        CFG_LONG    = 3'd3,
        CFG_LOCKOUT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_PRESS   = 1'b0,
        MODE_RELEASE = 1'b1
    } t_mode;

    typedef struct packed {
        logic       enable;
        t_mode      mode;
        logic [7:0] short_ticks;
        logic [7:0] long_ticks;
        logic [7:0] lockout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       fire;
        logic [7:0] code;
    } t_event;

endpackage

`default_nettype wire

FILE: src/kpsl_cfg.sv
`default_nettype none

module kpsl_cfg
    import kpsl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire logic [2:0] i_index,
    input  wire logic [7:0] i_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= RST_ENABLE;
            r_cfg.mode          <= t_mode'(RST_MODE);
            r_cfg.short_ticks   <= RST_SHORT;
            r_cfg.long_ticks    <= RST_LONG;
            r_cfg.lockout_ticks <= RST_LOCKOUT;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ENABLE:  r_cfg.enable        <= i_data[0];
                CFG_MODE:    r_cfg.mode          <= t_mode'(i_data[0]);
                CFG_SHORT:   r_cfg.short_ticks   <= i_data;
                CFG_LONG:    r_cfg.long_ticks    <= i_data;
                CFG_LOCKOUT: r_cfg.lockout_ticks <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/kpsl_core.sv
`default_nettype none

module kpsl_core
    import kpsl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_present,
    input  wire logic [3:0] i_key,
    input  wire t_cfg       i_cfg,
    output t_event          o_event
);

    logic [7:0] r_hold;
    logic [3:0] r_saved;
    logic [7:0] r_lock;
    logic [7:0] n_hold;
    logic [3:0] n_saved;
    logic [7:0] n_lock;

    logic [7:0] hold_inc;
    logic [8:0] hold_wide;
    logic       hit_short;
    logic       hit_long;
    logic       same_key;
    logic [7:0] key_plus;
    logic [7:0] saved_plus;

    always_comb begin
        hold_inc   = r_hold + 8'd1;
        hold_wide  = {1'b0, r_hold} + 9'd1;
        hit_short  = (hold_inc == i_cfg.short_ticks);
        hit_long   = (hold_inc == i_cfg.long_ticks);
        same_key   = (r_saved == i_key);
        key_plus   = {4'd0, i_key} + 8'd1;
        saved_plus = {4'd0, r_saved} + 8'd1;

        n_hold       = r_hold;
        n_saved      = r_saved;
        n_lock       = r_lock;
        o_event.fire = 1'b0;
        o_event.code = 8'd0;

        if (i_cfg.enable) begin
            unique case (i_cfg.mode)
                MODE_PRESS: begin
                    if (!i_present) begin
                        if (r_lock != 8'd0) begin
                            n_lock = r_lock - 8'd1;
                        end
                        n_hold = 8'd0;
                    end else begin
                        n_hold  = hold_inc;
                        n_saved = i_key;
                        if (hit_short) begin
                            n_lock = i_cfg.lockout_ticks;
                            if (r_lock == 8'd0 && same_key) begin
                                o_event.fire = 1'b1;
                            end
                        end
                        if (hit_long) begin
                            n_hold = hold_inc - REPEAT_STEP;
                            if (same_key) begin
                                o_event.fire = 1'b1;
                            end
                        end
                        if (o_event.fire) begin
                            o_event.code = key_plus;
                        end
                    end
                end
                MODE_RELEASE: begin
                    if (!i_present) begin
                        priority if (r_hold == i_cfg.long_ticks) begin
                            o_event.fire = 1'b1;
                            o_event.code = LONG_BASE + {4'd0, r_saved};
                        end else if (r_hold > i_cfg.short_ticks) begin
                            o_event.fire = 1'b1;
                            o_event.code = saved_plus;
                        end else begin
                        end
                        n_hold = 8'd0;
                    end else begin
                        priority if (r_hold == 8'd0) begin
                            n_saved = i_key;
                            n_hold  = 8'd1;
                        end else if (r_hold == 8'd1) begin
                            n_hold = same_key ? 8'd2 : 8'd0;
                        end else if (hold_wide > {1'b0, i_cfg.long_ticks}) begin
                            n_hold = i_cfg.long_ticks;
                        end else begin
                            n_hold = hold_wide[7:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= 8'd0;
            r_saved <= 4'd0;
            r_lock  <= 8'd0;
        end else if (i_step) begin
            r_hold  <= n_hold;
            r_saved <= n_saved;
            r_lock  <= n_lock;
        end
    end

endmodule

`default_nettype wire

FILE: src/key_press_short_long_detector_unit.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_key_present, i_key_code
// out      output     o_out_valid / i_out_ready  o_event_valid, o_event_code
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A scan beat is held in the input register and evaluated against the hold, key
// and lockout registers on its way into the result register. One beat per cycle
// is sustained unless the output stalls. Every input beat yields exactly one
// output beat. A stalled output register holds back the input register and then
// the input channel. Reset is synchronous and restores the register defaults.
`default_nettype none

module key_press_short_long_detector_unit
    import kpsl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_key_present,
    input  wire logic [3:0] i_key_code,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_event_valid,
    output logic [7:0]      o_event_code,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg       cfg;
    t_event     event_nxt;
    logic       r_in_valid;
    logic       r_present;
    logic [3:0] r_key;
    logic       r_out_valid;
    t_event     r_event;
    logic       out_free;
    logic       step;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;

    kpsl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kpsl_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_present (r_present),
        .i_key     (r_key),
        .i_cfg     (cfg),
        .o_event   (event_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_present <= i_key_present;
            r_key     <= i_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event <= event_nxt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_event.fire;
    assign o_event_code  = r_event.code;

endmodule

`default_nettype wire

FILE: src/kpsl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module kpsl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_event_valid,
    input wire logic [7:0] o_event_code,
    input wire logic       o_cfg_ready
);

    logic       out_stall;
    logic       out_quiet;
    logic       out_fire;
    logic       code_ok;
    logic [8:0] out_beat;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_quiet = o_out_valid && !o_event_valid;
    assign out_fire  = o_out_valid && o_event_valid;
    assign out_beat  = {o_event_valid, o_event_code};
    assign code_ok   = (o_event_code >= 8'd1 && o_event_code <= 8'd16) ||
                       (o_event_code >= 8'd49 && o_event_code <= 8'd64);

    `KPSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_beat))
    `KPSL_ASSERT_IMP(a_quiet_code, i_clk, i_rst_n, out_quiet, o_event_code == 8'd0)
    `KPSL_ASSERT_IMP(a_code_range, i_clk, i_rst_n, out_fire, code_ok)
    `KPSL_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready && o_cfg_ready)

endmodule

bind key_press_short_long_detector_unit kpsl_checker u_kpsl_checker (.*);

`default_nettype wire
